>>> hdl/abd_pkg.sv
// Shared types, constants and the sigmoid function of the anchor box decoder.
package abd_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int RSP_DEPTH = 4;
   localparam int NUM_CSR = 8;
   localparam logic [4:0] ELEM_DECODE = 5'd20;
   localparam logic [3:0] LAST_FIELD = 4'd14;
   localparam logic [3:0] FIELD_CONF = 4'd4;
   localparam logic [3:0] FIELD_FIRST_LM = 4'd5;

   localparam logic [2:0] CSR_CONF_THRESH = 3'd0;
   localparam logic [2:0] CSR_STRIDE = 3'd1;
   localparam logic [2:0] CSR_PRIOR_W0 = 3'd2;
   localparam logic [2:0] CSR_PRIOR_H0 = 3'd3;
   localparam logic [2:0] CSR_PRIOR_W1 = 3'd4;
   localparam logic [2:0] CSR_PRIOR_H1 = 3'd5;
   localparam logic [2:0] CSR_PRIOR_W2 = 3'd6;
   localparam logic [2:0] CSR_PRIOR_H2 = 3'd7;

   // bit 4 set: element is not stored
   localparam logic [4:0] ELEM_SLOT [21] = '{
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5,
      5'd6, 5'd7, 5'd16, 5'd8, 5'd9, 5'd16, 5'd10, 5'd11, 5'd16,
      5'd12, 5'd13, 5'd16, 5'd14, 5'd15, 5'd16
   };

   localparam logic [15:0] SIG_TAB [17] = '{
      16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
      16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
      16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
   };

   typedef struct packed {
      logic [15:0] conf_thresh;
      logic [6:0]  stride;
      logic [2:0][9:0] prior_w;
      logic [2:0][9:0] prior_h;
   } cfg_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0][15:0] vals;
      logic [6:0] column;
      logic [6:0] grid_row;
      logic [1:0] anchor_sel;
   } job_type;

   typedef struct packed {
      logic [3:0] field_index;
      logic signed [17:0] value;
      logic last;
   } rsp_type;

   function automatic logic [15:0] sigmoid(input logic signed [15:0] x);
      logic [16:0] a;
      logic [3:0] i;
      logic [6:0] f;
      logic [15:0] d;
      logic [19:0] p;
      logic [15:0] t;
      a = x[15] ? 17'(-{x[15], x}) : {1'b0, x};
      i = a[10:7];
      f = a[6:0];
      d = SIG_TAB[5'({1'b0, i} + 5'd1)] - SIG_TAB[i];
      p = 20'(d[12:0]) * 20'(f);
      if (a >= 17'd2048) begin
         t = SIG_TAB[16];
      end else begin
         t = SIG_TAB[i] + 16'((p + 20'd64) >> 7);
      end
      if (x[15]) begin
         t = 16'(17'd65536 - 17'(t));
      end
      return t;
   endfunction

   function automatic logic signed [17:0] sat18(input logic signed [49:0] v);
      logic signed [17:0] r;
      if (v > 50'sd131071) begin
         r = 18'sh1FFFF;
      end else if (v < -50'sd131072) begin
         r = 18'sh20000;
      end else begin
         r = v[17:0];
      end
      return r;
   endfunction

endpackage

>>> hdl/abd_front.sv
// Front end: cell value buffer and the job queue toward the decoder.
module abd_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic signed [15:0] req_feature_value,
   input  logic [4:0] req_element_index,
   input  logic [6:0] req_column,
   input  logic [6:0] req_grid_row,
   input  logic [1:0] req_anchor_sel,
   output logic job_valid,
   output abd_pkg::job_type job_out,
   input  logic job_pop
);

   logic [abd_pkg::NUM_SLOTS-1:0][15:0] buf_ff;
   abd_pkg::job_type jq_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic accept, store, push;
   logic [4:0] slot;
   abd_pkg::job_type job_new;

   assign req_full = (cnt_ff == 2'd2);
   assign accept = req_push && !req_full;
   assign slot = (req_element_index < abd_pkg::ELEM_DECODE) ?
                 abd_pkg::ELEM_SLOT[req_element_index] : 5'd16;
   assign store = accept && !slot[4];
   assign push = accept && (req_element_index == abd_pkg::ELEM_DECODE);
   assign job_valid = (cnt_ff != 2'd0);
   assign job_out = jq_ff[rd_ptr_ff];

   always_comb begin
      job_new.vals = buf_ff;
      job_new.column = req_column;
      job_new.grid_row = req_grid_row;
      job_new.anchor_sel = req_anchor_sel;
      cnt_in = cnt_ff + 2'(push) - 2'(job_pop && job_valid);
   end

   always_ff @(posedge clock) begin
      if (store) begin
         buf_ff[slot[3:0]] <= req_feature_value;
      end
      if (push) begin
         jq_ff[wr_ptr_ff] <= job_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (job_pop && job_valid) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> hdl/abd_back.sv
// Back end: sequencer that decodes one queued cell and emits its result words.
module abd_back #(
   parameter int GRID_SIZE = 128,
   parameter int ANCHOR_COUNT = 3
) (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  abd_pkg::job_type job_in,
   output logic job_pop,
   input  abd_pkg::cfg_type cfg,
   input  logic rsp_full,
   output logic rsp_push,
   output abd_pkg::rsp_type rsp_word
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SIG  = 4'd1;
   localparam logic [3:0] ST_CONF = 4'd2;
   localparam logic [3:0] ST_CHK  = 4'd3;
   localparam logic [3:0] ST_WSQ  = 4'd4;
   localparam logic [3:0] ST_WMUL = 4'd5;
   localparam logic [3:0] ST_HSQ  = 4'd6;
   localparam logic [3:0] ST_HMUL = 4'd7;
   localparam logic [3:0] ST_SIZE = 4'd8;
   localparam logic [3:0] ST_CX   = 4'd9;
   localparam logic [3:0] ST_CY   = 4'd10;
   localparam logic [3:0] ST_EMIT = 4'd11;

   logic [3:0] state_ff, state_in;
   abd_pkg::job_type job_ff;
   logic [2:0] cnt_ff;
   logic [3:0] k_ff;
   logic [15:0] sig_ff [6];
   logic [31:0] prod_ff;
   logic [15:0] conf_ff;
   logic [33:0] sq_ff;
   logic [43:0] w_ff, h_ff;
   logic signed [32:0] cx_ff, cy_ff;

   logic [32:0] conf_sum;
   logic [15:0] conf_val;
   logic tag_bad, conf_bad, size_bad;
   logic [9:0] aw, ah;
   logic [16:0] tw, th;
   logic [47:0] w10, h3;
   logic signed [24:0] cx_inner, cy_inner;
   logic signed [32:0] st_s;
   logic signed [49:0] pos_v, half_v, box_r, wh_r, lm_r;
   logic signed [18:0] lm_inner;
   logic signed [26:0] lm_p;
   logic [6:0] lm_pos;
   logic signed [17:0] val;

   always_comb begin
      case (job_ff.anchor_sel)
         2'd0: begin
            aw = cfg.prior_w[0];
            ah = cfg.prior_h[0];
         end
         2'd1: begin
            aw = cfg.prior_w[1];
            ah = cfg.prior_h[1];
         end
         2'd2: begin
            aw = cfg.prior_w[2];
            ah = cfg.prior_h[2];
         end
         default: begin
            aw = 10'd0;
            ah = 10'd0;
         end
      endcase
   end

   always_comb begin
      conf_sum = {1'b0, prod_ff} + 33'd32768;
      conf_val = conf_sum[31:16];
      tag_bad = (job_ff.anchor_sel >= 2'(ANCHOR_COUNT)) ||
                ({4'b0, job_ff.column} >= 11'(GRID_SIZE)) ||
                ({4'b0, job_ff.grid_row} >= 11'(GRID_SIZE));
      conf_bad = conf_val < cfg.conf_thresh;
      tw = {sig_ff[2], 1'b0};
      th = {sig_ff[3], 1'b0};
      w10 = 48'(w_ff) * 48'd10;
      h3 = 48'(h_ff) * 48'd3;
      size_bad = (w_ff < (44'd10 << 32)) || (h_ff < (44'd10 << 32)) ||
                 (w_ff > (44'd500 << 32)) || (h_ff > (44'd500 << 32)) ||
                 (w10 < h3) || (48'(w_ff) > h3);
      st_s = 33'($signed({1'b0, cfg.stride}));
      cx_inner = $signed({8'b0, sig_ff[0], 1'b0}) - 25'sd32768 +
                 $signed({2'b0, job_ff.column, 16'b0});
      cy_inner = $signed({8'b0, sig_ff[1], 1'b0}) - 25'sd32768 +
                 $signed({2'b0, job_ff.grid_row, 16'b0});
   end

   always_comb begin
      pos_v = k_ff[0] ? {cy_ff[32], cy_ff, 16'b0} : {cx_ff[32], cx_ff, 16'b0};
      half_v = k_ff[0] ? $signed({7'b0, h_ff[43:1]}) : $signed({7'b0, w_ff[43:1]});
      box_r = (pos_v - half_v + 50'sd134217728) >>> 28;
      wh_r = ($signed({6'b0, (k_ff[0] ? h_ff : w_ff)}) + 50'sd134217728) >>> 28;
      lm_pos = k_ff[0] ? job_ff.column : job_ff.grid_row;
      lm_inner = $signed({{2{job_ff.vals[0][15]}}, job_ff.vals[0], 1'b0}) - 19'sd128 +
                 $signed({4'b0, lm_pos, 8'b0});
      lm_p = 27'(lm_inner) * 27'($signed({1'b0, cfg.stride}));
      lm_r = (50'(lm_p) + 50'sd8) >>> 4;
      case (k_ff)
         4'd0, 4'd1: val = abd_pkg::sat18(box_r);
         4'd2, 4'd3: val = abd_pkg::sat18(wh_r);
         abd_pkg::FIELD_CONF: val = $signed({2'b0, conf_ff});
         default: val = abd_pkg::sat18(lm_r);
      endcase
      rsp_word.field_index = k_ff;
      rsp_word.value = val;
      rsp_word.last = (k_ff == abd_pkg::LAST_FIELD);
   end

   assign job_pop = (state_ff == ST_IDLE) && job_valid;
   assign rsp_push = (state_ff == ST_EMIT) && !rsp_full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (job_valid) state_in = ST_SIG;
         ST_SIG:  if (cnt_ff == 3'd5) state_in = ST_CONF;
         ST_CONF: state_in = ST_CHK;
         ST_CHK:  state_in = (tag_bad || conf_bad) ? ST_IDLE : ST_WSQ;
         ST_WSQ:  state_in = ST_WMUL;
         ST_WMUL: state_in = ST_HSQ;
         ST_HSQ:  state_in = ST_HMUL;
         ST_HMUL: state_in = ST_SIZE;
         ST_SIZE: state_in = size_bad ? ST_IDLE : ST_CX;
         ST_CX:   state_in = ST_CY;
         ST_CY:   state_in = ST_EMIT;
         ST_EMIT: if (rsp_push && rsp_word.last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= 3'd0;
         k_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= (state_ff == ST_SIG) ? cnt_ff + 3'd1 : 3'd0;
         if (state_ff != ST_EMIT) begin
            k_ff <= 4'd0;
         end else if (rsp_push) begin
            k_ff <= k_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_in;
      end
      if (state_ff == ST_SIG) begin
         sig_ff[cnt_ff] <= abd_pkg::sigmoid(job_ff.vals[0]);
         job_ff.vals <= job_ff.vals >> 16;
      end
      if (rsp_push && (k_ff >= abd_pkg::FIELD_FIRST_LM)) begin
         job_ff.vals <= job_ff.vals >> 16;
      end
      if (state_ff == ST_CONF) begin
         prod_ff <= 32'(sig_ff[4]) * 32'(sig_ff[5]);
      end
      if (state_ff == ST_CHK) begin
         conf_ff <= conf_val;
      end
      if (state_ff == ST_WSQ) begin
         sq_ff <= 34'(tw) * 34'(tw);
      end
      if (state_ff == ST_WMUL) begin
         w_ff <= 44'(sq_ff) * 44'(aw);
      end
      if (state_ff == ST_HSQ) begin
         sq_ff <= 34'(th) * 34'(th);
      end
      if (state_ff == ST_HMUL) begin
         h_ff <= 44'(sq_ff) * 44'(ah);
      end
      if (state_ff == ST_CX) begin
         cx_ff <= 33'(cx_inner) * st_s;
      end
      if (state_ff == ST_CY) begin
         cy_ff <= 33'(cy_inner) * st_s;
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff == ST_SIG)
      else $error("job taken outside idle");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp_word.last |=> state_ff == ST_IDLE)
      else $error("sequencer did not finish after last word");
   a_sig_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIG |-> cnt_ff <= 3'd5)
      else $error("sigmoid count overrun");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_full |-> !rsp_push)
      else $error("word pushed into full queue");

endmodule

>>> hdl/abd_rsp_fifo.sv
// Result word queue between the decoder and the result port.
module abd_rsp_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  abd_pkg::rsp_type wdata,
   output logic full,
   input  logic pop,
   output logic empty,
   output abd_pkg::rsp_type rdata
);

   localparam int AW = $clog2(abd_pkg::RSP_DEPTH);

   abd_pkg::rsp_type mem_ff [abd_pkg::RSP_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0] cnt_ff, cnt_in;
   logic do_pop;

   assign full = (cnt_ff == (AW+1)'(abd_pkg::RSP_DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_pop = pop && !empty;
   assign rdata = mem_ff[rd_ff];
   assign cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + AW'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> hdl/anchor_box_decode_filtered_core.sv
// Anchor box decoder top level: registers, front end, decoder and result queue.
// Input: one head value per word with element index, column, row and anchor,
// taken when req_push is high and req_full low. Element 20 closes a cell and
// hands a snapshot of the buffered values to a two-entry job queue; the
// visibility elements are dropped.
// Results: while rsp_empty is low the oldest word is on rsp_*; rsp_pop takes it.
// A kept box gives 15 words, field 0 to 14, rsp_last on the final one; a
// dropped cell gives none.
// The decoder runs the sigmoid lookups and the multiply chain, then emits the
// words, and takes no new cell until it is done; the job queue absorbs
// bursts and the input stalls when the decoder runs behind. The first result
// word reaches the result queue after the lookups, checks and centre products.
// A stalled result port fills the 4-word result queue, then halts the decoder,
// then the job queue, then req_full rises. Nothing is lost.
// Reset clears the queues and the sequencer and loads register defaults;
// the cell buffer is not cleared. csr_we writes register csr_index at once.
module anchor_box_decode_filtered_core #(
   parameter int GRID_SIZE = 128,
   parameter int ANCHOR_COUNT = 3
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic signed [15:0] req_feature_value,
   input  logic [4:0] req_element_index,
   input  logic [6:0] req_column,
   input  logic [6:0] req_grid_row,
   input  logic [1:0] req_anchor_sel,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [3:0] rsp_field_index,
   output logic signed [17:0] rsp_value,
   output logic rsp_last,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_wdata
);

   abd_pkg::cfg_type cfg_ff;
   abd_pkg::job_type job;
   abd_pkg::rsp_type word_in, word_out;
   logic job_valid, job_pop, fifo_full, fifo_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_thresh <= 16'd32768;
         cfg_ff.stride <= 7'd8;
         cfg_ff.prior_w[0] <= 10'd4;
         cfg_ff.prior_h[0] <= 10'd5;
         cfg_ff.prior_w[1] <= 10'd6;
         cfg_ff.prior_h[1] <= 10'd8;
         cfg_ff.prior_w[2] <= 10'd10;
         cfg_ff.prior_h[2] <= 10'd12;
      end else if (csr_we) begin
         case (csr_index)
            abd_pkg::CSR_CONF_THRESH: cfg_ff.conf_thresh <= csr_wdata;
            abd_pkg::CSR_STRIDE:   cfg_ff.stride <= csr_wdata[6:0];
            abd_pkg::CSR_PRIOR_W0: cfg_ff.prior_w[0] <= csr_wdata[9:0];
            abd_pkg::CSR_PRIOR_H0: cfg_ff.prior_h[0] <= csr_wdata[9:0];
            abd_pkg::CSR_PRIOR_W1: cfg_ff.prior_w[1] <= csr_wdata[9:0];
            abd_pkg::CSR_PRIOR_H1: cfg_ff.prior_h[1] <= csr_wdata[9:0];
            abd_pkg::CSR_PRIOR_W2: cfg_ff.prior_w[2] <= csr_wdata[9:0];
            abd_pkg::CSR_PRIOR_H2: cfg_ff.prior_h[2] <= csr_wdata[9:0];
            default: cfg_ff.stride <= cfg_ff.stride;
         endcase
      end
   end

   abd_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_feature_value(req_feature_value),
      .req_element_index(req_element_index),
      .req_column(req_column),
      .req_grid_row(req_grid_row),
      .req_anchor_sel(req_anchor_sel),
      .job_valid(job_valid),
      .job_out(job),
      .job_pop(job_pop)
   );

   abd_back #(
      .GRID_SIZE(GRID_SIZE),
      .ANCHOR_COUNT(ANCHOR_COUNT)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(job_valid),
      .job_in(job),
      .job_pop(job_pop),
      .cfg(cfg_ff),
      .rsp_full(fifo_full),
      .rsp_push(fifo_push),
      .rsp_word(word_in)
   );

   abd_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push(fifo_push),
      .wdata(word_in),
      .full(fifo_full),
      .pop(rsp_pop),
      .empty(rsp_empty),
      .rdata(word_out)
   );

   assign rsp_field_index = word_out.field_index;
   assign rsp_value = word_out.value;
   assign rsp_last = word_out.last;

endmodule

>>> tb/sv/tb_anchor_box_decode_filtered_core.sv
// Self-checking testbench for the anchor box decoder with landmark outputs.
module tb_anchor_box_decode_filtered_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 150;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic signed [15:0] req_feature_value;
   logic [4:0] req_element_index;
   logic [6:0] req_column;
   logic [6:0] req_grid_row;
   logic [1:0] req_anchor_sel;
   logic rsp_empty;
   logic rsp_pop;
   logic [3:0] rsp_field_index;
   logic signed [17:0] rsp_value;
   logic rsp_last;
   logic csr_we;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;

   anchor_box_decode_filtered_core dut (.*);

   // predictor state
   logic [15:0] thr_q16;
   logic [6:0] stride_px;
   logic [9:0] anc_w [3];
   logic [9:0] anc_h [3];
   logic signed [15:0] cell_vals [16];
   abd_pkg::rsp_type box_words [$];

   int errors = 0;
   int words_checked = 0;
   int boxes_kept = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   localparam longint SIG_POINTS [17] = '{
      32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
      64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint sig_lut(input logic signed [15:0] x);
      longint a;
      longint t;
      longint i;
      a = (x < 0) ? -longint'(x) : longint'(x);
      if (a >= 2048) begin
         t = SIG_POINTS[16];
      end else begin
         i = a >> 7;
         t = SIG_POINTS[i] + (((SIG_POINTS[i+1] - SIG_POINTS[i]) * (a & 127) + 64) >> 7);
      end
      if (x < 0) begin
         t = 65536 - t;
      end
      return t;
   endfunction

   function automatic longint round_q(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic signed [17:0] clamp18(input longint v);
      if (v > 131071) begin
         return 18'sd131071;
      end else if (v < -131072) begin
         return -18'sd131072;
      end
      return v[17:0];
   endfunction

   task automatic predict_cell_words(input logic signed [15:0] val, input logic [4:0] elem,
                                     input logic [6:0] col, input logic [6:0] row,
                                     input logic [1:0] anch);
      longint res [15];
      longint conf, w32, h32, tw, th, st, cx, cy, kx, ky;
      int m;
      abd_pkg::rsp_type w;
      if (elem < abd_pkg::ELEM_DECODE) begin
         if (elem < 6) begin
            cell_vals[elem] = val;
         end else begin
            m = elem - 6;
            if (m % 3 != 2) begin
               cell_vals[6 + 2 * (m / 3) + m % 3] = val;
            end
         end
         return;
      end
      if (elem != abd_pkg::ELEM_DECODE || anch > 2) begin
         return;
      end
      conf = (sig_lut(cell_vals[4]) * sig_lut(cell_vals[5]) + 32768) >> 16;
      if (conf < longint'(thr_q16)) begin
         return;
      end
      st = stride_px;
      tw = 2 * sig_lut(cell_vals[2]);
      th = 2 * sig_lut(cell_vals[3]);
      w32 = tw * tw * longint'(anc_w[anch]);
      h32 = th * th * longint'(anc_h[anch]);
      if (w32 < (longint'(10) << 32) || h32 < (longint'(10) << 32)) begin
         return;
      end
      if (w32 > (longint'(500) << 32) || h32 > (longint'(500) << 32)) begin
         return;
      end
      if (10 * w32 < 3 * h32 || w32 > 3 * h32) begin
         return;
      end
      cx = (2 * sig_lut(cell_vals[0]) - 32768 + longint'(col) * 65536) * st;
      cy = (2 * sig_lut(cell_vals[1]) - 32768 + longint'(row) * 65536) * st;
      res[0] = round_q(cx * 65536 - w32 / 2, 28);
      res[1] = round_q(cy * 65536 - h32 / 2, 28);
      res[2] = round_q(w32, 28);
      res[3] = round_q(h32, 28);
      res[4] = conf;
      for (int k = 0; k < 5; k++) begin
         kx = cell_vals[6 + 2 * k];
         ky = cell_vals[7 + 2 * k];
         res[5 + 2 * k] = round_q((2 * kx - 128 + longint'(col) * 256) * st, 4);
         res[6 + 2 * k] = round_q((2 * ky - 128 + longint'(row) * 256) * st, 4);
      end
      for (int k = 0; k < 15; k++) begin
         w.field_index = 4'(k);
         w.value = clamp18(res[k]);
         w.last = (4'(k) == abd_pkg::LAST_FIELD);
         box_words = {box_words, w};
      end
      boxes_kept++;
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         abd_pkg::CSR_CONF_THRESH: thr_q16 = data;
         abd_pkg::CSR_STRIDE: stride_px = data[6:0];
         abd_pkg::CSR_PRIOR_W0: anc_w[0] = data[9:0];
         abd_pkg::CSR_PRIOR_H0: anc_h[0] = data[9:0];
         abd_pkg::CSR_PRIOR_W1: anc_w[1] = data[9:0];
         abd_pkg::CSR_PRIOR_H1: anc_h[1] = data[9:0];
         abd_pkg::CSR_PRIOR_W2: anc_w[2] = data[9:0];
         default: anc_h[2] = data[9:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_word(input logic signed [15:0] val, input logic [4:0] elem,
                            input logic [6:0] col, input logic [6:0] row,
                            input logic [1:0] anch);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_feature_value <= val;
      req_element_index <= elem;
      req_column <= col;
      req_grid_row <= row;
      req_anchor_sel <= anch;
      do @(posedge clock); while (req_full);
      predict_cell_words(val, elem, col, row, anch);
   endtask

   // cell, maybe noisy; mostly confident, sizes around the anchor
   task automatic send_cell(input logic [6:0] col, input logic [6:0] row,
                            input logic [1:0] anch, input bit noisy);
      logic signed [15:0] v;
      for (int e = 0; e <= 20; e++) begin
         if (noisy && $urandom_range(9) == 0) begin
            send_word(16'($urandom), 5'($urandom_range(21, 31)), col, row, anch);
         end
         if (noisy && e != 20 && $urandom_range(19) == 0) begin
            continue;
         end
         v = 16'($urandom);
         if (e == 2 || e == 3) begin
            v = 16'($urandom_range(0, 1536)) - 16'sd512;
         end else if ((e == 4 || e == 5) && $urandom_range(4) != 0) begin
            v = 16'($urandom_range(256, 3000));
         end
         send_word(v, 5'(e), col, row, anch);
      end
   endtask

   // size equals the anchor, confidence near one; kept if registers allow
   task automatic send_fixed_cell(input logic [6:0] col, input logic [6:0] row,
                                  input logic [1:0] anch);
      logic signed [15:0] v;
      for (int e = 0; e <= 20; e++) begin
         v = 16'($urandom);
         if (e < 4) begin
            v = 16'sd0;
         end else if (e < 6) begin
            v = 16'sd2048;
         end
         send_word(v, 5'(e), col, row, anch);
      end
   endtask

   // decode the buffered values again under fresh tags
   task automatic send_decodes(input int n);
      for (int i = 0; i < n; i++) begin
         send_word(16'($urandom), abd_pkg::ELEM_DECODE, 7'($urandom), 7'($urandom),
                   2'($urandom_range(0, 2)));
      end
   endtask

   task automatic send_random_cells(input int n);
      for (int c = 0; c < n; c++) begin
         send_cell(7'($urandom), 7'($urandom), 2'($urandom_range(0, 2)), 1'b1);
      end
   endtask

   task automatic wait_drain();
      req_push <= 1'b0;
      while (box_words.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_anchors(input logic [15:0] w, input logic [15:0] h);
      write_reg(abd_pkg::CSR_PRIOR_W0, w);
      write_reg(abd_pkg::CSR_PRIOR_H0, h);
      write_reg(abd_pkg::CSR_PRIOR_W1, w + 16'd7);
      write_reg(abd_pkg::CSR_PRIOR_H1, h);
      write_reg(abd_pkg::CSR_PRIOR_W2, w);
      write_reg(abd_pkg::CSR_PRIOR_H2, h + 16'd9);
   endtask

   task automatic test_directed_extremes();
      for (int e = 0; e <= 20; e++) begin
         case (e)
            0, 4, 5: send_word(16'sh7FFF, 5'(e), 7'd127, 7'd127, 2'd2);
            1: send_word(-16'sh8000, 5'(e), 7'd127, 7'd127, 2'd2);
            2, 3: send_word(16'sd2048, 5'(e), 7'd127, 7'd127, 2'd2);
            default: send_word((e % 2) ? -16'sh8000 : 16'sh7FFF, 5'(e), 7'd127, 7'd127,
                               2'd2);
         endcase
      end
      send_word(16'sd0, 5'd31, 7'd0, 7'd0, 2'd0);
      send_word(16'sd0, 5'd21, 7'd0, 7'd0, 2'd0);
      send_word(16'sd5, abd_pkg::ELEM_DECODE, 7'd3, 7'd9, 2'd3);
      send_word(16'sd0, abd_pkg::ELEM_DECODE, 7'd0, 7'd0, 2'd0);
      send_word(-16'sd300, 5'd4, 7'd1, 7'd1, 2'd1);
      send_word(16'sd0, abd_pkg::ELEM_DECODE, 7'd1, 7'd1, 2'd1);
      settle();
   endtask

   task automatic test_register_extremes();
      write_reg(abd_pkg::CSR_STRIDE, 16'd64);
      set_anchors(16'd1023, 16'd1023);
      write_reg(abd_pkg::CSR_CONF_THRESH, 16'd0);
      send_random_cells(1);
      settle();
      write_reg(abd_pkg::CSR_STRIDE, 16'd1);
      set_anchors(16'd1, 16'd1);
      write_reg(abd_pkg::CSR_CONF_THRESH, 16'd65535);
      send_word(16'sd0, abd_pkg::ELEM_DECODE, 7'd10, 7'd10, 2'd0);
      settle();
   endtask

   task automatic test_idle_phases();
      write_reg(abd_pkg::CSR_CONF_THRESH, 16'd20000);
      write_reg(abd_pkg::CSR_STRIDE, 16'd32);
      set_anchors(16'd60, 16'd55);
      send_fixed_cell(7'd40, 7'd17, 2'd1);
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 51 : 6) : 0;
         recv_stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 51 : 6) : 0;
         send_word(16'($urandom), 5'($urandom_range(6, 19)), 7'd40, 7'd17, 2'd1);
         send_decodes(5);
         wait_drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      settle();
   endtask

   task automatic test_backpressure();
      hold_left = 300;
      send_decodes(6);
      settle();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_pop <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      abd_pkg::rsp_type w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (box_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word field %0d", rsp_field_index));
         end else begin
            w = box_words.pop_front();
            words_checked++;
            if (rsp_field_index !== w.field_index) begin
               report_mismatch($sformatf("field_index %0d, want %0d",
                                         rsp_field_index, w.field_index));
            end
            if (rsp_value !== w.value) begin
               report_mismatch($sformatf("value %0d, want %0d (field %0d)",
                                         rsp_value, w.value, w.field_index));
            end
            if (rsp_last !== w.last) begin
               report_mismatch($sformatf("last %0b, want %0b (field %0d)",
                                         rsp_last, w.last, w.field_index));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_feature_value = '0;
      req_element_index = '0;
      req_column = '0;
      req_grid_row = '0;
      req_anchor_sel = '0;
      rsp_pop = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      thr_q16 = 16'd32768;
      stride_px = 7'd8;
      anc_w = '{10'd4, 10'd6, 10'd10};
      anc_h = '{10'd5, 10'd8, 10'd12};
      foreach (cell_vals[i]) cell_vals[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_register_extremes();
      test_idle_phases();
      test_backpressure();
      if (box_words.size() != 0) begin
         report_mismatch($sformatf("%0d words never arrived", box_words.size()));
      end
      $display("covered: extreme values and registers, dropped and ignored words,");
      $display("idle and stall phases, full-queue stall; %0d boxes, %0d words checked",
               boxes_kept, words_checked);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
